// ===== rtl/exit_stack_length_balancer_defines.svh =====
// ----------------------------------------------------------------------------
// exit_stack_length_balancer_defines
// Assertion macros used by the checker file of the balancer.
// ----------------------------------------------------------------------------
`ifndef EXIT_STACK_LENGTH_BALANCER_DEFINES_SVH
`define EXIT_STACK_LENGTH_BALANCER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, held off during reset
`define ESL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("esl checker: same-cycle property violated");

// Next-cycle implication, sampled on i_clk, held off during reset
`define ESL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("esl checker: next-cycle property violated");

`endif

// ===== rtl/esl_pkg.sv =====
// ----------------------------------------------------------------------------
// esl_pkg
// Types and constants shared by the exit stack length balancer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package esl_pkg;

    localparam int NUM_DIRS    = 4;
    localparam int DIR_W       = 2;
    localparam int NEED_W      = 6;
    localparam int LEN_W       = 4;
    localparam int EXTRA_W     = 8;
    localparam int MAX_ARM_LEN = 15;

    typedef logic [NEED_W-1:0]  t_need;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [DIR_W-1:0]   t_dir;
    typedef logic [EXTRA_W-1:0] t_extra;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OVERFLOW,
        ST_QUOTA,
        ST_REPORT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic ovf_step;
        logic qta_step;
        logic finish;
        logic finish_ok;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic extra_zero;
        logic ovf_dst_ok;
        logic src_ok;
        logic qdst_ok;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/esl_ctrl.sv =====
// ----------------------------------------------------------------------------
// esl_ctrl
// Controller: sequences load, overflow moves, quota moves and the report.
// ----------------------------------------------------------------------------
`default_nettype none

module esl_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire esl_pkg::t_status i_status,
    output esl_pkg::t_cmd         o_cmd,
    output logic                  busy,
    output logic                  o_done
);
    import esl_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state, return to idle on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_OVERFLOW;
                end
            end
            ST_OVERFLOW: begin
                if (i_status.extra_zero) begin
                    n_state = ST_QUOTA;
                end else if (!i_status.ovf_dst_ok) begin
                    n_state = ST_REPORT;
                end
            end
            ST_QUOTA: begin
                if (!i_status.src_ok || !i_status.qdst_ok) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs; refuse transfers while reset is held
    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy       = !i_rst_n;
                o_cmd.load = start && i_rst_n;
            end
            ST_OVERFLOW: begin
                if (!i_status.extra_zero) begin
                    if (i_status.ovf_dst_ok) begin
                        o_cmd.ovf_step = 1'b1;
                    end else begin
                        o_cmd.finish = 1'b1;
                    end
                end
            end
            ST_QUOTA: begin
                if (!i_status.src_ok) begin
                    o_cmd.finish    = 1'b1;
                    o_cmd.finish_ok = 1'b1;
                end else if (i_status.qdst_ok) begin
                    o_cmd.qta_step = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                end
            end
            ST_REPORT: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/esl_datapath.sv =====
// ----------------------------------------------------------------------------
// esl_datapath
// Datapath: per-arm length registers, overflow counter, move selection and
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module esl_datapath (
    input  wire logic           i_clk,
    input  wire esl_pkg::t_cmd  i_cmd,
    input  wire esl_pkg::t_need i_need  [esl_pkg::NUM_DIRS],
    input  wire esl_pkg::t_len  i_arm   [esl_pkg::NUM_DIRS],
    input  wire esl_pkg::t_len  i_quota [esl_pkg::NUM_DIRS],
    output esl_pkg::t_status o_status,
    output esl_pkg::t_len  o_final_len [esl_pkg::NUM_DIRS],
    output logic           o_feasible
);
    import esl_pkg::*;

    localparam t_len ARM_CAP = LEN_W'(MAX_ARM_LEN);

    t_len   r_arm     [NUM_DIRS];
    t_len   r_quota   [NUM_DIRS];
    t_len   r_len     [NUM_DIRS];
    logic   r_over    [NUM_DIRS];
    t_extra r_extra;
    t_len   r_out_len [NUM_DIRS];
    logic   r_out_ok;

    t_len   ld_arm  [NUM_DIRS];
    t_len   ld_len  [NUM_DIRS];
    logic   ld_over [NUM_DIRS];
    t_extra ld_extra;

    logic   ovf_found;
    t_dir   ovf_dst;
    logic   src_found;
    t_dir   src_idx;
    t_len   src_exc;
    logic   qdst_found;
    t_dir   qdst_idx;
    t_len   qdst_slack;

    // Initial lengths and summed overflow of a new item
    always_comb begin
        t_need need_eff;
        ld_extra = '0;
        for (int d = 0; d < NUM_DIRS; d++) begin
            ld_arm[d]  = (i_arm[d] > ARM_CAP) ? ARM_CAP : i_arm[d];
            need_eff   = (ld_arm[d] == '0) ? '0 : i_need[d];
            ld_over[d] = need_eff > NEED_W'(ld_arm[d]);
            ld_len[d]  = ld_over[d] ? ld_arm[d] : need_eff[LEN_W-1:0];
            if (ld_over[d]) begin
                ld_extra = ld_extra + EXTRA_W'(need_eff - NEED_W'(ld_arm[d]));
            end
        end
    end

    // Overflow destination: shortest present arm that is not over and not full
    always_comb begin
        ovf_found = 1'b0;
        ovf_dst   = '0;
        for (int d = 0; d < NUM_DIRS; d++) begin
            if (!r_over[d] && r_arm[d] != '0 && r_len[d] < r_arm[d] &&
                (!ovf_found || r_len[d] < r_len[ovf_dst])) begin
                ovf_found = 1'b1;
                ovf_dst   = DIR_W'(d);
            end
        end
    end

    // Quota source (largest excess) and destination (largest slack)
    always_comb begin
        t_len diff;
        src_found  = 1'b0;
        src_idx    = '0;
        src_exc    = '0;
        qdst_found = 1'b0;
        qdst_idx   = '0;
        qdst_slack = '0;
        for (int d = 0; d < NUM_DIRS; d++) begin
            diff = r_len[d] - r_quota[d];
            if (r_len[d] > r_quota[d] && (!src_found || diff > src_exc)) begin
                src_found = 1'b1;
                src_idx   = DIR_W'(d);
                src_exc   = diff;
            end
        end
        for (int d = 0; d < NUM_DIRS; d++) begin
            diff = r_quota[d] - r_len[d];
            if (DIR_W'(d) != src_idx && r_arm[d] != '0 && r_quota[d] > r_len[d] &&
                (!qdst_found || diff > qdst_slack)) begin
                qdst_found = 1'b1;
                qdst_idx   = DIR_W'(d);
                qdst_slack = diff;
            end
        end
    end

    assign o_status.extra_zero = (r_extra == '0);
    assign o_status.ovf_dst_ok = ovf_found;
    assign o_status.src_ok     = src_found;
    assign o_status.qdst_ok    = qdst_found;

    // Load, move one unit, or capture the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_arm   <= ld_arm;
            r_quota <= i_quota;
            r_len   <= ld_len;
            r_over  <= ld_over;
            r_extra <= ld_extra;
        end else if (i_cmd.ovf_step) begin
            r_len[ovf_dst] <= r_len[ovf_dst] + LEN_W'(1);
            r_extra        <= r_extra - EXTRA_W'(1);
        end else if (i_cmd.qta_step) begin
            r_len[src_idx]  <= r_len[src_idx] - LEN_W'(1);
            r_len[qdst_idx] <= r_len[qdst_idx] + LEN_W'(1);
        end
        if (i_cmd.finish) begin
            for (int d = 0; d < NUM_DIRS; d++) begin
                r_out_len[d] <= i_cmd.finish_ok ? r_len[d] : '0;
            end
            r_out_ok <= i_cmd.finish_ok;
        end
    end

    assign o_final_len = r_out_len;
    assign o_feasible  = r_out_ok;

endmodule

`default_nettype wire

// ===== rtl/exit_stack_length_balancer.sv =====
// ----------------------------------------------------------------------------
// exit_stack_length_balancer
// Predicts the final stack length on each of four exit arms.
// ----------------------------------------------------------------------------
// Usage:
//   Drive need, arm length and quota of all four arms and raise start. The
//   item transfers at a rising edge with start high and busy low; busy then
//   stays high until the result has been shown.
//   The result appears on o_final_len_0..3 and o_feasible for one cycle,
//   marked by o_done. The receiver cannot stall; it must take the result in
//   that cycle. An infeasible item reports all lengths zero, o_feasible low.
// Timing:
//   One unit moves per cycle, first overflow units, then quota units. The
//   next item may transfer in the cycle after o_done.
// Reset:
//   Synchronous, active low on i_rst_n; busy stays high while reset is held,
//   the controller returns to idle and any item in flight is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module exit_stack_length_balancer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire esl_pkg::t_need       i_need_0,
    input  wire esl_pkg::t_need       i_need_1,
    input  wire esl_pkg::t_need       i_need_2,
    input  wire esl_pkg::t_need       i_need_3,
    input  wire esl_pkg::t_len        i_arm_len_0,
    input  wire esl_pkg::t_len        i_arm_len_1,
    input  wire esl_pkg::t_len        i_arm_len_2,
    input  wire esl_pkg::t_len        i_arm_len_3,
    input  wire esl_pkg::t_len        i_quota_0,
    input  wire esl_pkg::t_len        i_quota_1,
    input  wire esl_pkg::t_len        i_quota_2,
    input  wire esl_pkg::t_len        i_quota_3,
    output logic                      o_done,
    output esl_pkg::t_len             o_final_len_0,
    output esl_pkg::t_len             o_final_len_1,
    output esl_pkg::t_len             o_final_len_2,
    output esl_pkg::t_len             o_final_len_3,
    output logic                      o_feasible
);
    import esl_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_need   need  [NUM_DIRS];
    t_len    arm   [NUM_DIRS];
    t_len    quota [NUM_DIRS];
    t_len    final_len [NUM_DIRS];

    // Gather per-arm inputs
    assign need  = '{i_need_0, i_need_1, i_need_2, i_need_3};
    assign arm   = '{i_arm_len_0, i_arm_len_1, i_arm_len_2, i_arm_len_3};
    assign quota = '{i_quota_0, i_quota_1, i_quota_2, i_quota_3};

    esl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    esl_datapath u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_need      (need),
        .i_arm       (arm),
        .i_quota     (quota),
        .o_status    (status),
        .o_final_len (final_len),
        .o_feasible  (o_feasible)
    );

    // Spread per-arm results
    assign o_final_len_0 = final_len[0];
    assign o_final_len_1 = final_len[1];
    assign o_final_len_2 = final_len[2];
    assign o_final_len_3 = final_len[3];

endmodule

`default_nettype wire

// ===== rtl/esl_checker.sv =====
// ----------------------------------------------------------------------------
// esl_checker
// Port-level assertions for the exit stack length balancer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "exit_stack_length_balancer_defines.svh"

module esl_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_done,
    input wire esl_pkg::t_len o_final_len_0,
    input wire esl_pkg::t_len o_final_len_1,
    input wire esl_pkg::t_len o_final_len_2,
    input wire esl_pkg::t_len o_final_len_3,
    input wire logic          o_feasible
);
    import esl_pkg::*;

    // A transfer makes the block busy in the next cycle
    `ESL_ASSERT_NXT(a_start_busy, start && !busy, busy && !o_done)
    // A result is only shown while the block is busy
    `ESL_ASSERT_IMP(a_done_busy, o_done, busy)
    // The result strobe lasts one cycle and frees the block
    `ESL_ASSERT_NXT(a_done_pulse, o_done, !o_done && !busy)
    // An infeasible result reports zero lengths
    `ESL_ASSERT_IMP(a_infeasible_zero, o_done && !o_feasible, o_final_len_0 == '0 && o_final_len_1 == '0 && o_final_len_2 == '0 && o_final_len_3 == '0)

endmodule

bind exit_stack_length_balancer esl_checker u_esl_checker (.*);

`default_nettype wire
